### design/sdm_pkg.sv
// Shared types and constants for the signed division magic number block.
package sdm_pkg;

   // Fixed port widths.
   localparam int OPERAND_BITS  = 64;
   localparam int SHIFT_BITS    = 6;
   localparam int WORD_BITS_DEF = 64;

   // Operand pair loaded into the shared divider.
   typedef enum logic [1:0] {
      DIV_SRC_MOD = 2'd0,   // t mod |d|
      DIV_SRC_Q1  = 2'd1,   // 2^(W-1) / anc
      DIV_SRC_Q2  = 2'd2    // 2^(W-1) / |d|
   } div_src_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic        load;
      logic        div_start;
      div_src_type div_src;
      logic        div_step;
      logic        anc_set;
      logic        q1_set;
      logic        q2_set;
      logic        iter_step;
      logic        delta_set;
      logic        out_set;
   } sdm_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_tiny;   // divisor magnitude below two
      logic stop;      // doubling loop has reached its end condition
   } sdm_status_type;

endpackage

### design/sdm_dpath.sv
// Datapath: divisor magnitude, shared restoring divider, doubling loop and result registers.
module sdm_dpath import sdm_pkg::*; #(
   parameter int WORD_BITS = WORD_BITS_DEF
) (
   input  logic                           clock,
   input  sdm_cmd_type                    cmd,
   output sdm_status_type                 status,
   input  logic signed [OPERAND_BITS-1:0] req_divisor,
   output logic        [OPERAND_BITS-1:0] rsp_magic_multiplier,
   output logic        [SHIFT_BITS-1:0]   rsp_post_shift,
   output logic                           rsp_valid_res
);

   localparam logic [WORD_BITS-1:0] HALF    = {1'b1, {(WORD_BITS-1){1'b0}}};
   localparam logic [WORD_BITS-1:0] HALF_M1 = {1'b0, {(WORD_BITS-1){1'b1}}};

   logic [WORD_BITS-1:0]  d_word;
   logic [WORD_BITS-1:0]  ad_in;
   logic [WORD_BITS-1:0]  ad_ff;
   logic                  neg_ff;
   logic [WORD_BITS-1:0]  anc_raw;
   logic [WORD_BITS-1:0]  anc_ff;

   logic [WORD_BITS-1:0]  div_num_ff;
   logic [WORD_BITS-1:0]  div_den_ff;
   logic [WORD_BITS-1:0]  div_rem_ff;
   logic [WORD_BITS:0]    div_trial;
   logic                  div_ge;
   logic [WORD_BITS-1:0]  div_num_in;
   logic [WORD_BITS-1:0]  div_den_in;

   logic [WORD_BITS-1:0]  q1_ff;
   logic [WORD_BITS-1:0]  r1_ff;
   logic [WORD_BITS-1:0]  q2_ff;
   logic [WORD_BITS-1:0]  r2_ff;
   logic [WORD_BITS-1:0]  r1_dbl;
   logic [WORD_BITS-1:0]  r2_dbl;
   logic                  r1_ge;
   logic                  r2_ge;
   logic [WORD_BITS-1:0]  delta_ff;
   logic [WORD_BITS-1:0]  q2p1_ff;
   logic [SHIFT_BITS-1:0] shift_ff;
   logic [WORD_BITS-1:0]  magic_word;

   // Only the low word of the divisor counts; take its magnitude.
   assign d_word = req_divisor[WORD_BITS-1:0];
   assign ad_in  = d_word[WORD_BITS-1] ? ('0 - d_word) : d_word;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ad_ff  <= ad_in;
         neg_ff <= d_word[WORD_BITS-1];
      end
   end

   assign status.is_tiny = (ad_ff[WORD_BITS-1:1] == '0);

   // Operand selection for the shared divider.
   always_comb begin
      case (cmd.div_src)
         DIV_SRC_MOD: begin
            div_num_in = neg_ff ? (HALF | WORD_BITS'(1)) : HALF;
            div_den_in = ad_ff;
         end
         DIV_SRC_Q1: begin
            div_num_in = HALF;
            div_den_in = anc_ff;
         end
         DIV_SRC_Q2: begin
            div_num_in = HALF;
            div_den_in = ad_ff;
         end
         default: begin
            div_num_in = HALF;
            div_den_in = ad_ff;
         end
      endcase
   end

   // Restoring divider: one quotient bit per cycle, quotient builds up in div_num_ff.
   assign div_trial = {div_rem_ff, div_num_ff[WORD_BITS-1]};
   assign div_ge    = (div_trial >= {1'b0, div_den_ff});

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         div_num_ff <= div_num_in;
         div_den_ff <= div_den_in;
         div_rem_ff <= '0;
      end else if (cmd.div_step) begin
         div_num_ff <= {div_num_ff[WORD_BITS-2:0], div_ge};
         div_rem_ff <= div_ge ? WORD_BITS'(div_trial - {1'b0, div_den_ff})
                              : div_trial[WORD_BITS-1:0];
      end
   end

   // anc = t - 1 - (t mod |d|), never zero.
   assign anc_raw = (neg_ff ? HALF : HALF_M1) - div_rem_ff;

   always_ff @(posedge clock) begin
      if (cmd.anc_set) begin
         anc_ff <= (anc_raw == '0) ? WORD_BITS'(1) : anc_raw;
      end
   end

   // Doubling step of both quotient and remainder pairs.
   assign r1_dbl = {r1_ff[WORD_BITS-2:0], 1'b0};
   assign r2_dbl = {r2_ff[WORD_BITS-2:0], 1'b0};
   assign r1_ge  = (r1_dbl >= anc_ff);
   assign r2_ge  = (r2_dbl >= ad_ff);

   always_ff @(posedge clock) begin
      if (cmd.q1_set) begin
         q1_ff <= div_num_ff;
         r1_ff <= div_rem_ff;
      end else if (cmd.iter_step) begin
         q1_ff <= {q1_ff[WORD_BITS-2:0], r1_ge};
         r1_ff <= r1_ge ? (r1_dbl - anc_ff) : r1_dbl;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.q2_set) begin
         q2_ff    <= div_num_ff;
         r2_ff    <= div_rem_ff;
         shift_ff <= '1;
      end else if (cmd.iter_step) begin
         q2_ff    <= {q2_ff[WORD_BITS-2:0], r2_ge};
         r2_ff    <= r2_ge ? (r2_dbl - ad_ff) : r2_dbl;
         shift_ff <= shift_ff + 1'b1;
      end
   end

   // Distance to the stopping bound, and the unsigned multiplier candidate.
   always_ff @(posedge clock) begin
      if (cmd.delta_set) begin
         delta_ff <= ad_ff - r2_ff;
         q2p1_ff  <= q2_ff + 1'b1;
      end
   end

   assign status.stop = !((q1_ff < delta_ff) || ((q1_ff == delta_ff) && (r1_ff == '0)));

   // Result registers; a tiny divisor gives an all-zero result.
   assign magic_word = neg_ff ? ('0 - q2p1_ff) : q2p1_ff;

   always_ff @(posedge clock) begin
      if (cmd.out_set) begin
         if (status.is_tiny) begin
            rsp_magic_multiplier <= '0;
            rsp_post_shift       <= '0;
            rsp_valid_res        <= 1'b0;
         end else begin
            rsp_magic_multiplier <= OPERAND_BITS'(magic_word);
            rsp_post_shift       <= shift_ff;
            rsp_valid_res        <= 1'b1;
         end
      end
   end

endmodule

### design/sdm_ctrl.sv
// Controller: sequences the three divisions, the doubling loop and the result handshake.
module sdm_ctrl import sdm_pkg::*; #(
   parameter int WORD_BITS = WORD_BITS_DEF
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   input  sdm_status_type status,
   output sdm_cmd_type    cmd
);

   localparam int CNT_BITS = $clog2(WORD_BITS);
   localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(WORD_BITS - 1);

   typedef enum logic [12:0] {
      ST_IDLE      = 13'b0000000000001,
      ST_START_MOD = 13'b0000000000010,
      ST_DIV_MOD   = 13'b0000000000100,
      ST_SET_ANC   = 13'b0000000001000,
      ST_START_Q1  = 13'b0000000010000,
      ST_DIV_Q1    = 13'b0000000100000,
      ST_CAP_Q1    = 13'b0000001000000,
      ST_DIV_Q2    = 13'b0000010000000,
      ST_CAP_Q2    = 13'b0000100000000,
      ST_STEP      = 13'b0001000000000,
      ST_DELTA     = 13'b0010000000000,
      ST_CHECK     = 13'b0100000000000,
      ST_FINISH    = 13'b1000000000000
   } state_type;

   state_type           state_ff, state_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                cnt_last;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign cnt_last  = (cnt_ff == CNT_LAST);

   // Next state, counter and datapath commands.
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      cmd.div_src = DIV_SRC_MOD;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_START_MOD;
            end
         end
         ST_START_MOD: begin
            cnt_in = '0;
            if (status.is_tiny) begin
               state_in = ST_FINISH;
            end else begin
               cmd.div_start = 1'b1;
               cmd.div_src   = DIV_SRC_MOD;
               state_in      = ST_DIV_MOD;
            end
         end
         ST_DIV_MOD: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_last) begin
               cnt_in   = '0;
               state_in = ST_SET_ANC;
            end
         end
         ST_SET_ANC: begin
            cmd.anc_set = 1'b1;
            state_in    = ST_START_Q1;
         end
         ST_START_Q1: begin
            cmd.div_start = 1'b1;
            cmd.div_src   = DIV_SRC_Q1;
            state_in      = ST_DIV_Q1;
         end
         ST_DIV_Q1: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_last) begin
               cnt_in   = '0;
               state_in = ST_CAP_Q1;
            end
         end
         ST_CAP_Q1: begin
            // Capture the first quotient while the divider reloads.
            cmd.q1_set    = 1'b1;
            cmd.div_start = 1'b1;
            cmd.div_src   = DIV_SRC_Q2;
            state_in      = ST_DIV_Q2;
         end
         ST_DIV_Q2: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_last) begin
               cnt_in   = '0;
               state_in = ST_CAP_Q2;
            end
         end
         ST_CAP_Q2: begin
            cmd.q2_set = 1'b1;
            cnt_in     = '0;
            state_in   = ST_STEP;
         end
         ST_STEP: begin
            cmd.iter_step = 1'b1;
            state_in      = ST_DELTA;
         end
         ST_DELTA: begin
            cmd.delta_set = 1'b1;
            state_in      = ST_CHECK;
         end
         ST_CHECK: begin
            // The loop ends on its condition or after a full word of steps.
            if (status.stop || cnt_last) begin
               state_in = ST_FINISH;
            end else begin
               cnt_in   = cnt_ff + 1'b1;
               state_in = ST_STEP;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_set = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result valid holds until the receiver takes the item.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.out_set) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### design/signed_division_magic_number.sv
// Top level of the signed division magic number generator.
//
// Takes one signed divisor item on the req_ channel (valid/ready) and returns
// one item on the rsp_ channel: the multiply-high magic multiplier, the
// arithmetic post-shift, and a flag that is low for divisors 0, 1 and -1
// (those items carry zero multiplier and shift).
// Only the low WORD_BITS bits of the divisor are used; the multiplier comes
// back zero-extended to 64 bits.
// The three divisions go one bit per cycle through a single shared
// restoring divider, and each doubling step goes through an update, a
// bound and a compare state; the loop runs at most WORD_BITS steps. A
// divisor of magnitude below two skips the divisions and the loop.
// One item is worked on at a time; req_ready is high only while idle, so
// a new item is only taken once the last result is in the output register.
// A finished result sits in the output register, so a new item is accepted
// while the receiver stalls; the next result waits until that one is taken.
// Reset returns the controller to idle and drops rsp_valid.
module signed_division_magic_number import sdm_pkg::*; #(
   parameter int WORD_BITS = WORD_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [OPERAND_BITS-1:0] req_divisor,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic        [OPERAND_BITS-1:0] rsp_magic_multiplier,
   output logic        [SHIFT_BITS-1:0]   rsp_post_shift,
   output logic                           rsp_valid_res
);

   sdm_cmd_type    cmd;
   sdm_status_type status;

   // Sequencer.
   sdm_ctrl #(
      .WORD_BITS (WORD_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Arithmetic and result registers.
   sdm_dpath #(
      .WORD_BITS (WORD_BITS)
   ) u_dpath (
      .clock                (clock),
      .cmd                  (cmd),
      .status               (status),
      .req_divisor          (req_divisor),
      .rsp_magic_multiplier (rsp_magic_multiplier),
      .rsp_post_shift       (rsp_post_shift),
      .rsp_valid_res        (rsp_valid_res)
   );

endmodule

### design/sdm_checker.sv
// Port-level checks for the signed division magic number block, bound to the top level.
module sdm_checker import sdm_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic [OPERAND_BITS-1:0] rsp_magic_multiplier,
   input logic [SHIFT_BITS-1:0]   rsp_post_shift,
   input logic                    rsp_valid_res
);

   // A stalled result item stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp_valid dropped before the item was taken");

   // A stalled result item keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_magic_multiplier)
         && $stable(rsp_post_shift) && $stable(rsp_valid_res))
      else $error("rsp payload changed while stalled");

   // A result for a divisor of magnitude below two is all zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_valid_res |-> rsp_magic_multiplier == '0 && rsp_post_shift == '0)
      else $error("invalid result carries nonzero fields");

   // One item at a time: the block is busy right after accepting an item.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req_ready stayed high after an accepted item");

   // No result can appear the cycle after an accept unless one was already pending.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid |=> !rsp_valid)
      else $error("result appeared too early after an accepted item");

endmodule

bind signed_division_magic_number sdm_checker u_sdm_checker (.*);
